// ----- rtl/assert_macros.svh -----
// assertion helpers used by the checker file tshi_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, off while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// next-cycle implication, also checked across reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/tshi_pkg.sv -----
// ----------------------------------------------------------------------------
// tshi_pkg
// Types and constants of the tile surface height interpolator.
// ----------------------------------------------------------------------------
package tshi_pkg;

   localparam int MAP_SIDE_DEF    = 64;
   localparam int HEIGHT_BITS_DEF = 8;

   localparam int OP_BITS    = 2;
   localparam int POS_BITS   = 28;
   localparam int CELL_BITS  = 12;
   localparam int VALUE_BITS = 8;
   localparam int SHAPE_BITS = 2;
   localparam int Z_BITS     = 26;

   // position layout: tile in the top bits, in-tile fraction below it
   localparam int TILE_LSB   = 22;
   localparam int TILE_BITS  = POS_BITS - TILE_LSB;
   localparam int FRAC_LSB   = 6;
   localparam int FRAC_BITS  = 16;
   localparam int WIDE_BITS  = 16;

   localparam logic [OP_BITS-1:0] OP_WRITE   = 2'd0;
   localparam logic [OP_BITS-1:0] OP_FLOOR   = 2'd1;
   localparam logic [OP_BITS-1:0] OP_CEILING = 2'd2;

   localparam logic [SHAPE_BITS-1:0] KIND_FLAT  = 2'd0;
   localparam logic [SHAPE_BITS-1:0] KIND_SLOPE = 2'd1;
   localparam logic [SHAPE_BITS-1:0] KIND_TRI_A = 2'd2;
   localparam logic [SHAPE_BITS-1:0] KIND_TRI_B = 2'd3;

   typedef struct packed {
      logic [OP_BITS-1:0]    op;
      logic [POS_BITS-1:0]   x_pos;
      logic [POS_BITS-1:0]   y_pos;
      logic [CELL_BITS-1:0]  cell_index;
      logic [VALUE_BITS-1:0] floor_value;
      logic [VALUE_BITS-1:0] ceiling_value;
      logic [SHAPE_BITS-1:0] floor_shape;
      logic [SHAPE_BITS-1:0] ceiling_shape;
   } req_payload_type;

   typedef struct packed {
      logic signed [Z_BITS-1:0] height_z;
      logic                     was_query;
   } rsp_payload_type;

endpackage

// ----- rtl/tshi_ram.sv -----
// ----------------------------------------------------------------------------
// tshi_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module tshi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ----- rtl/tile_surface_height_interp.sv -----
// ----------------------------------------------------------------------------
// tile_surface_height_interp
// Height map of square tiles with flat, sloped and triangle surfaces.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item per transfer. op write loads one map cell (floor
//   and ceiling height, floor and ceiling kind); op floor or ceiling asks for
//   the interpolated height at a 6.22 position. Every item gives exactly one
//   transfer on rsp_*: was_query 1 with the height in signed 10.16, or was_query 0
//   and height 0 for writes and the unused op code.
//   Throughput is one item per cycle unless rsp_ready stalls. A request
//   passes seven registers to rsp_valid (tile lookup, map read, corner
//   rebuild, multiply along x, edge sums, multiply along y, output register
//   holding the final sum), the first loaded at the transfer edge.
//   The four corners of a tile come from two copies of the map, each RAM
//   giving two reads per cycle; writes go to both copies.
//   Each stage moves on when the stage after it is empty or moving, so a
//   stall on rsp_ready fills the pipeline before req_ready drops, and a
//   bubble never blocks input. Reset empties the pipeline; map contents
//   are kept and the whole map must be written before any query.
// ----------------------------------------------------------------------------
module tile_surface_height_interp
   import tshi_pkg::*;
#(
   parameter int MAP_SIDE    = MAP_SIDE_DEF,
   parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   localparam int H         = HEIGHT_BITS;
   localparam int CELLS     = MAP_SIDE * MAP_SIDE;
   localparam int IW        = $clog2(CELLS);
   localparam int COLW      = $clog2(MAP_SIDE);
   localparam int TILE_CNT  = 2 ** TILE_BITS;
   localparam int WORD_W    = 2 * H + 2 * SHAPE_BITS;
   localparam int CW        = H + 2;             // rebuilt corner, whole units
   localparam int DW        = H + 3;             // corner difference
   localparam int PW        = H + 20;            // difference times fraction
   localparam int TW        = H + 18;            // top / bottom in (H+2).16
   localparam int DFW       = H + 19;            // bottom minus top
   localparam int QW        = H + 36;            // final product
   localparam int ZW        = (TW > Z_BITS) ? TW : Z_BITS;
   localparam int CMPW      = ((IW > CELL_BITS) ? IW : CELL_BITS) + 1;

   localparam logic [IW:0]      CELLS_EXT = (IW + 1)'(CELLS);
   localparam logic [IW-1:0]    SIDE_IDX  = IW'(MAP_SIDE);
   localparam logic [IW:0]      STEP_R    = (IW + 1)'(1);
   localparam logic [IW:0]      STEP_D    = (IW + 1)'(MAP_SIDE);
   localparam logic [IW:0]      STEP_DR   = (IW + 1)'(MAP_SIDE + 1);
   localparam logic [CMPW-1:0]  CELLS_CMP = CMPW'(CELLS);

   typedef logic [TILE_CNT-1:0][COLW-1:0] wrap_tab_type;

   // tile number modulo map side, built by counting so no division is needed
   function automatic wrap_tab_type build_wrap();
      wrap_tab_type tab;
      int           col;
      col = 0;
      for (int i = 0; i < TILE_CNT; i++) begin
         tab[i] = COLW'(col);
         col    = (col == MAP_SIDE - 1) ? 0 : col + 1;
      end
      return tab;
   endfunction

   localparam wrap_tab_type TILE_WRAP = build_wrap();

   function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
                                              input logic [IW:0]   step);
      logic [IW:0] sum;
      sum = {1'b0, base} + step;
      if (sum >= CELLS_EXT) begin
         sum = sum - CELLS_EXT;
      end
      return sum[IW-1:0];
   endfunction

   // ready chain: a stage takes a new item when empty or when it moves on
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, rsp_valid_ff;
   logic r1, r2, r3, r4, r5, r6, r_out;

   assign r_out     = !rsp_valid_ff || rsp_ready;
   assign r6        = !v6_ff || r_out;
   assign r5        = !v5_ff || r6;
   assign r4        = !v4_ff || r5;
   assign r3        = !v3_ff || r4;
   assign r2        = !v2_ff || r3;
   assign r1        = !v1_ff || r2;
   assign req_ready = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (r1) v1_ff <= req_valid;
         if (r2) v2_ff <= v1_ff;
         if (r3) v3_ff <= v2_ff;
         if (r4) v4_ff <= v3_ff;
         if (r5) v5_ff <= v4_ff;
         if (r6) v6_ff <= v5_ff;
         if (r_out) rsp_valid_ff <= v6_ff;
      end
   end

   // ---------------- stage 1: tile lookup and write data
   logic [WIDE_BITS-1:0] floor_wide, ceil_wide;
   logic [WORD_W-1:0]    wdata_in;

   assign floor_wide = WIDE_BITS'(req_data.floor_value);
   assign ceil_wide  = WIDE_BITS'(req_data.ceiling_value);
   assign wdata_in   = {req_data.ceiling_shape, req_data.floor_shape,
                        ceil_wide[H-1:0], floor_wide[H-1:0]};

   logic [OP_BITS-1:0]   op1_ff;
   logic [COLW-1:0]      tx1_ff, ty1_ff;
   logic [FRAC_BITS-1:0] fx1_ff, fy1_ff;
   logic [CELL_BITS-1:0] widx1_ff;
   logic [WORD_W-1:0]    wdata1_ff;

   always_ff @(posedge clock) begin
      if (r1) begin
         op1_ff    <= req_data.op;
         tx1_ff    <= TILE_WRAP[req_data.x_pos[POS_BITS-1:TILE_LSB]];
         ty1_ff    <= TILE_WRAP[req_data.y_pos[POS_BITS-1:TILE_LSB]];
         fx1_ff    <= req_data.x_pos[FRAC_LSB+FRAC_BITS-1:FRAC_LSB];
         fy1_ff    <= req_data.y_pos[FRAC_LSB+FRAC_BITS-1:FRAC_LSB];
         widx1_ff  <= req_data.cell_index;
         wdata1_ff <= wdata_in;
      end
   end

   // corner addresses, wrapping over the whole map
   logic [IW-1:0] spot, n_right, n_down, n_diag;
   logic          wr_en;

   assign spot    = IW'(ty1_ff) * SIDE_IDX + IW'(tx1_ff);
   assign n_right = wrap_add(spot, STEP_R);
   assign n_down  = wrap_add(spot, STEP_D);
   assign n_diag  = wrap_add(spot, STEP_DR);
   assign wr_en   = v1_ff && r2 && (op1_ff == OP_WRITE)
                    && (CMPW'(widx1_ff) < CELLS_CMP);

   logic [WORD_W-1:0] q1, q2, q3, q4;

   tshi_ram #(.WIDTH(WORD_W), .DEPTH(CELLS)) u_ram_upper (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (IW'(widx1_ff)),
      .wr_data   (wdata1_ff),
      .rd_en     (r2),
      .rd_addr_a (spot),
      .rd_addr_b (n_right),
      .rd_data_a (q1),
      .rd_data_b (q2)
   );

   tshi_ram #(.WIDTH(WORD_W), .DEPTH(CELLS)) u_ram_lower (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (IW'(widx1_ff)),
      .wr_data   (wdata1_ff),
      .rd_en     (r2),
      .rd_addr_a (n_down),
      .rd_addr_b (n_diag),
      .rd_data_a (q3),
      .rd_data_b (q4)
   );

   // ---------------- stage 2: map data, rebuild corners
   logic [OP_BITS-1:0]   op2_ff;
   logic [FRAC_BITS-1:0] fx2_ff, fy2_ff;

   always_ff @(posedge clock) begin
      if (r2) begin
         op2_ff <= op1_ff;
         fx2_ff <= fx1_ff;
         fy2_ff <= fy1_ff;
      end
   end

   logic                  is_ceil, is_query;
   logic [H-1:0]          h1, h2, h3, h4;
   logic [SHAPE_BITS-1:0] kind;
   logic signed [CW-1:0]  e1, e2, e3, e4;
   logic signed [CW-1:0]  c1_in, c2_in, c3_in, c4_in;
   logic [FRAC_BITS:0]    frac_sum;

   assign is_ceil  = (op2_ff == OP_CEILING);
   assign is_query = (op2_ff == OP_FLOOR) || (op2_ff == OP_CEILING);
   assign h1   = is_ceil ? q1[2*H-1:H] : q1[H-1:0];
   assign h2   = is_ceil ? q2[2*H-1:H] : q2[H-1:0];
   assign h3   = is_ceil ? q3[2*H-1:H] : q3[H-1:0];
   assign h4   = is_ceil ? q4[2*H-1:H] : q4[H-1:0];
   assign kind = is_ceil ? q1[2*H+2*SHAPE_BITS-1:2*H+SHAPE_BITS]
                         : q1[2*H+SHAPE_BITS-1:2*H];
   assign e1   = signed'({2'b00, h1});
   assign e2   = signed'({2'b00, h2});
   assign e3   = signed'({2'b00, h3});
   assign e4   = signed'({2'b00, h4});
   assign frac_sum = {1'b0, fx2_ff} + {1'b0, fy2_ff};

   // every kind becomes a bilinear blend of four (possibly rebuilt) corners
   always_comb begin
      c1_in = e1;
      c2_in = e2;
      c3_in = e3;
      c4_in = e4;
      case (kind)
         KIND_FLAT: begin
            c2_in = e1;
            c3_in = e1;
            c4_in = e1;
         end
         KIND_SLOPE: begin
            if (h1 == h2) begin
               c2_in = e1;
               c4_in = e3;
            end else begin
               c3_in = e1;
               c4_in = e2;
            end
         end
         KIND_TRI_A: begin
            if (fx2_ff > fy2_ff) begin
               c3_in = e1 + e1 - e2;
            end else begin
               c2_in = e1 + e1 - e3;
            end
         end
         KIND_TRI_B: begin
            // fx below one minus fy: the sum does not reach one
            if (!frac_sum[FRAC_BITS]) begin
               c4_in = e2 + e2 - e1;
            end else begin
               c1_in = e2 + e2 - e4;
            end
         end
         default: begin
            c1_in = e1;
         end
      endcase
      if (!is_query) begin
         c1_in = '0;
         c2_in = '0;
         c3_in = '0;
         c4_in = '0;
      end
   end

   // ---------------- stage 3: corner differences times fx
   logic signed [CW-1:0]  c1_3_ff, c2_3_ff, c3_3_ff, c4_3_ff;
   logic [FRAC_BITS-1:0]  fx3_ff, fy3_ff;
   logic                  q3_ff;

   always_ff @(posedge clock) begin
      if (r3) begin
         c1_3_ff <= c1_in;
         c2_3_ff <= c2_in;
         c3_3_ff <= c3_in;
         c4_3_ff <= c4_in;
         fx3_ff  <= fx2_ff;
         fy3_ff  <= fy2_ff;
         q3_ff   <= is_query;
      end
   end

   logic signed [DW-1:0]        d_top, d_bot;
   logic signed [FRAC_BITS:0]   fx_s;
   logic signed [PW-1:0]        p_top_in, p_bot_in;

   assign d_top    = DW'(c2_3_ff) - DW'(c1_3_ff);
   assign d_bot    = DW'(c4_3_ff) - DW'(c3_3_ff);
   assign fx_s     = signed'({1'b0, fx3_ff});
   assign p_top_in = d_top * fx_s;
   assign p_bot_in = d_bot * fx_s;

   // ---------------- stage 4: top and bottom edges
   logic signed [PW-1:0]  p_top_ff, p_bot_ff;
   logic signed [CW-1:0]  c1_4_ff, c3_4_ff;
   logic [FRAC_BITS-1:0]  fy4_ff;
   logic                  q4_ff;

   always_ff @(posedge clock) begin
      if (r4) begin
         p_top_ff <= p_top_in;
         p_bot_ff <= p_bot_in;
         c1_4_ff  <= c1_3_ff;
         c3_4_ff  <= c3_3_ff;
         fy4_ff   <= fy3_ff;
         q4_ff    <= q3_ff;
      end
   end

   logic signed [TW-1:0] top_in, bot_in;

   // exact sums: both fit TW, so truncating the product is harmless
   assign top_in = (TW'(c1_4_ff) <<< FRAC_BITS) + TW'(p_top_ff);
   assign bot_in = (TW'(c3_4_ff) <<< FRAC_BITS) + TW'(p_bot_ff);

   // ---------------- stage 5: blend along y
   logic signed [TW-1:0]  top5_ff, bot5_ff;
   logic [FRAC_BITS-1:0]  fy5_ff;
   logic                  q5_ff;

   always_ff @(posedge clock) begin
      if (r5) begin
         top5_ff <= top_in;
         bot5_ff <= bot_in;
         fy5_ff  <= fy4_ff;
         q5_ff   <= q4_ff;
      end
   end

   logic signed [DFW-1:0]     diff;
   logic signed [FRAC_BITS:0] fy_s;
   logic signed [QW-1:0]      prod_in;

   assign diff    = DFW'(bot5_ff) - DFW'(top5_ff);
   assign fy_s    = signed'({1'b0, fy5_ff});
   assign prod_in = diff * fy_s;

   // ---------------- stage 6: final sum, arithmetic shift rounds down
   logic signed [TW-1:0] top6_ff;
   logic signed [QW-1:0] prod6_ff;
   logic                 q6_ff;

   always_ff @(posedge clock) begin
      if (r6) begin
         top6_ff  <= top5_ff;
         prod6_ff <= prod_in;
         q6_ff    <= q5_ff;
      end
   end

   logic signed [QW-1:0] prod_shift;
   logic signed [ZW-1:0] z_in;
   rsp_payload_type      rsp_in;

   assign prod_shift       = prod6_ff >>> FRAC_BITS;
   assign z_in             = ZW'(top6_ff) + ZW'(prod_shift);
   assign rsp_in.height_z  = z_in[Z_BITS-1:0];
   assign rsp_in.was_query = q6_ff;

   // ---------------- output register
   rsp_payload_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (r_out) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/tshi_checker.sv -----
// ----------------------------------------------------------------------------
// tshi_checker
// Port-level checks of the height interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tshi_checker
   import tshi_pkg::*;
#(
   parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
   input logic            clock,
   input logic            reset,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_data
);

   localparam longint HMAX = (longint'(1) << HEIGHT_BITS) - 1;
   localparam longint ZLO  = -(HMAX << FRAC_BITS);
   localparam longint ZHI  = 2 * (HMAX << FRAC_BITS);
   localparam bit     WIDE = (HEIGHT_BITS > 8);

   // a stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                rsp_valid && $stable(rsp_data))

   // nothing comes out right after reset
   `ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

   // writes and unused codes answer with height zero
   `ASSERT_IMPLY(a_ack_zero, clock, reset, rsp_valid && !rsp_data.was_query,
                 rsp_data.height_z == '0)

   // an interpolated height stays between the extremes of rebuilt corners (checked up to 8-bit heights)
   `ASSERT_IMPLY(a_z_range, clock, reset, rsp_valid && rsp_data.was_query,
                 WIDE || (longint'(rsp_data.height_z) >= ZLO && longint'(rsp_data.height_z) <= ZHI))

   // with the output empty the pipeline drains, so input is open
   `ASSERT_IMPLY(a_open_when_empty, clock, reset, !rsp_valid, req_ready)

endmodule

bind tile_surface_height_interp tshi_checker #(.HEIGHT_BITS(HEIGHT_BITS)) u_checker (.*);
